// ----- hw/rtl/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// stq_pkg: shared definitions of the sorted timer queue
// Field widths, opcode and result kind codes, and the remaining-time record
// passed from the compare unit to the sequencer.
// ----------------------------------------------------------------------------
package stq_pkg;

  // field widths
  localparam int TIME_W  = 32;
  localparam int DELAY_W = 16;
  localparam int TAG_W   = 8;
  localparam int KIND_W  = 2;
  localparam int UNTIL_W = 16;

  // default queue depth and per-tick expiry limit
  localparam int DEPTH_DEF = 16;
  localparam int MAX_OUT   = 16;

  // input opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ARMED     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TICK_NONE = 2'd3;

  // remaining-time view of one queue entry
  typedef struct packed {
    logic               due;         // deadline reached or overdue
    logic               later;       // still pending and later than the new delay
    logic [UNTIL_W-1:0] ticks_left;  // saturated ticks left, zero when due
  } stq_rem_t;

endpackage

// ----- hw/rtl/stq_cmp.sv -----
// ----------------------------------------------------------------------------
// stq_cmp: shared remaining-time unit
// One subtractor and one compare: remaining = deadline - now, classified as
// due, later than a given delay, and saturated to the until-next range.
// ----------------------------------------------------------------------------
module stq_cmp (
  input  logic [stq_pkg::TIME_W-1:0]  deadline,
  input  logic [stq_pkg::TIME_W-1:0]  now,
  input  logic [stq_pkg::DELAY_W-1:0] delay,
  output stq_pkg::stq_rem_t           rem
);

  logic [stq_pkg::TIME_W-1:0] diff;
  logic                       overdue;
  logic                       far;

  // remaining time modulo the time base
  assign diff    = deadline - now;
  assign overdue = diff[stq_pkg::TIME_W-1];
  assign far     = |diff[stq_pkg::TIME_W-1:stq_pkg::UNTIL_W];

  // classification
  always_comb begin
    rem.due   = (diff == '0) || overdue;
    rem.later = !overdue && (diff > stq_pkg::TIME_W'(delay));
    if (overdue) begin
      rem.ticks_left = '0;
    end else if (far) begin
      rem.ticks_left = '1;
    end else begin
      rem.ticks_left = diff[stq_pkg::UNTIL_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/stq_store.sv -----
// ----------------------------------------------------------------------------
// stq_store: entry memory of the timer queue
// One write port and one registered read port; each word holds a deadline
// and its callback tag.
// ----------------------------------------------------------------------------
module stq_store #(
  parameter int DEPTH = stq_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [stq_pkg::TIME_W-1:0] wr_deadline,
  input  logic [stq_pkg::TAG_W-1:0]  wr_tag,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic [stq_pkg::TIME_W-1:0] rd_deadline,
  output logic [stq_pkg::TAG_W-1:0]  rd_tag
);

  localparam int WORD_W = stq_pkg::TIME_W + stq_pkg::TAG_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tag, wr_deadline};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
  end

  assign rd_deadline = rd_q_r[stq_pkg::TIME_W-1:0];
  assign rd_tag      = rd_q_r[WORD_W-1:stq_pkg::TIME_W];

endmodule

// ----- hw/rtl/sorted_timer_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_timer_queue: one-shot timeouts sharing one time base
// Input items on in_*: in_tuser is the opcode (tick or arm), in_tdata holds
// the delay and the callback tag. An arm with zero delay expires at once; an
// arm into a full queue is rejected; otherwise the deadline is inserted in
// deadline order, equal deadlines keeping arrival order. A tick advances the
// time by one and emits every due entry, earliest first, up to 16 per tick.
// Every result carries the ticks left until the earliest pending deadline;
// out_tlast marks the final result of an input item.
// One item at a time: in_tready is high only in the idle state. An arm walks
// from the tail, moving each later entry up, then places the new one; a zero
// delay or a full queue skips the walk. A tick checks entries from the head
// until one is not due, the limit is reached or the queue runs out, then reads
// and emits each expired entry; each result waits for its output handshake.
// All steps share the single read port and the compare unit.
// While the receiver holds out_tready low the result stays in the output
// register and the sequencer waits. Reset empties the queue and clears the
// time; the entry memory needs no clearing.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
  parameter int DEPTH = stq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] delay, [23:16] tag
  input  logic [0:0]  in_tuser,   // [0] opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] expired_tag, [23:8] until_next
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int TW    = stq_pkg::TIME_W;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_HEAD_RD = 4'd1;
  localparam logic [3:0] S_HEAD_LD = 4'd2;
  localparam logic [3:0] S_INS_RD  = 4'd3;
  localparam logic [3:0] S_INS_CMP = 4'd4;
  localparam logic [3:0] S_INS_PUT = 4'd5;
  localparam logic [3:0] S_TK_RD   = 4'd6;
  localparam logic [3:0] S_TK_CMP  = 4'd7;
  localparam logic [3:0] S_TK_DONE = 4'd8;
  localparam logic [3:0] S_EM_RD   = 4'd9;
  localparam logic [3:0] S_EM_LD   = 4'd10;
  localparam logic [3:0] S_EM_OUT  = 4'd11;
  localparam logic [3:0] S_OUT_ONE = 4'd12;

  logic [3:0]                  state_r, state_nxt;
  logic [TW-1:0]               time_r, time_nxt;
  logic [IDX_W-1:0]            head_r, head_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            idx_r, idx_nxt;
  logic [CNT_W-1:0]            em_r, em_nxt;
  logic [stq_pkg::DELAY_W-1:0] delay_r, delay_nxt;
  logic [stq_pkg::TAG_W-1:0]   tag_r, tag_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [stq_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [stq_pkg::TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic [stq_pkg::UNTIL_W-1:0] out_until_r, out_until_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        in_acc;
  logic [stq_pkg::DELAY_W-1:0] in_delay;
  logic [stq_pkg::TAG_W-1:0]   in_tag;
  logic [CNT_W-1:0]            idx_dec;
  logic [CNT_W-1:0]            em_inc;
  logic [CNT_W-1:0]            rd_rel;
  logic [IDX_W-1:0]            rd_addr;
  logic [TW-1:0]               rd_deadline;
  logic [stq_pkg::TAG_W-1:0]   rd_tag;
  logic                        wr_en;
  logic                        wr_new;
  logic [IDX_W-1:0]            wr_addr;
  logic [TW-1:0]               wr_deadline;
  logic [stq_pkg::TAG_W-1:0]   wr_tag;
  logic [TW-1:0]               new_deadline;
  logic                        scan_room;
  stq_pkg::stq_rem_t           rem;

  // ring address: base plus offset, folded once into the depth
  function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign in_acc    = in_tvalid && in_tready;
  assign in_delay  = in_tdata[15:0];
  assign in_tag    = in_tdata[23:16];
  assign in_tready = (state_r == S_IDLE);

  assign idx_dec      = idx_r - CNT_W'(1);
  assign em_inc       = em_r + CNT_W'(1);
  assign new_deadline = time_r + TW'(delay_r);
  assign scan_room    = (32'(idx_r) < stq_pkg::MAX_OUT);

  // memory read offset per state
  always_comb begin
    unique case (state_r)
      S_INS_RD: rd_rel = idx_dec;
      S_TK_RD:  rd_rel = idx_r;
      S_EM_RD:  rd_rel = em_r;
      default:  rd_rel = '0;
    endcase
  end
  assign rd_addr = ring_addr(head_r, rd_rel);

  // memory write: shift one entry up during the walk, or place the new one
  assign wr_new      = (state_r == S_INS_PUT);
  assign wr_en       = wr_new || ((state_r == S_INS_CMP) && rem.later);
  assign wr_addr     = ring_addr(head_r, idx_r);
  assign wr_deadline = wr_new ? new_deadline : rd_deadline;
  assign wr_tag      = wr_new ? tag_r : rd_tag;

  stq_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_deadline (wr_deadline),
    .wr_tag      (wr_tag),
    .rd_addr     (rd_addr),
    .rd_deadline (rd_deadline),
    .rd_tag      (rd_tag)
  );

  stq_cmp u_cmp (
    .deadline (rd_deadline),
    .now      (time_r),
    .delay    (delay_r),
    .rem      (rem)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    time_nxt      = time_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    em_nxt        = em_r;
    delay_nxt     = delay_r;
    tag_nxt       = tag_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_tag_nxt   = out_tag_r;
    out_until_nxt = out_until_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          delay_nxt = in_delay;
          tag_nxt   = in_tag;
          idx_nxt   = '0;
          if (in_tuser[0] == stq_pkg::OP_ARM) begin
            if (in_delay == '0) begin
              out_kind_nxt = stq_pkg::KIND_EXPIRED;
              out_tag_nxt  = in_tag;
              state_nxt    = S_HEAD_RD;
            end else if (cnt_r == CNT_W'(DEPTH)) begin
              out_kind_nxt = stq_pkg::KIND_FULL;
              out_tag_nxt  = '0;
              state_nxt    = S_HEAD_RD;
            end else begin
              out_kind_nxt = stq_pkg::KIND_ARMED;
              out_tag_nxt  = in_tag;
              idx_nxt      = cnt_r;
              state_nxt    = (cnt_r == '0) ? S_INS_PUT : S_INS_RD;
            end
          end else begin
            time_nxt  = time_r + TW'(1);
            state_nxt = S_TK_RD;
          end
        end
      end
      // single result: until-next from the queue head
      S_HEAD_RD: begin
        state_nxt = S_HEAD_LD;
      end
      S_HEAD_LD: begin
        out_until_nxt = (cnt_r == '0) ? '0 : rem.ticks_left;
        out_last_nxt  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT_ONE;
      end
      // insert walk from the tail toward the head
      S_INS_RD: begin
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (rem.later) begin
          idx_nxt   = idx_dec;
          state_nxt = (idx_dec == '0) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_HEAD_RD;
      end
      // tick: count due entries from the head
      S_TK_RD: begin
        if (idx_r < cnt_r) begin
          state_nxt = S_TK_CMP;
        end else begin
          out_until_nxt = '0;
          state_nxt     = S_TK_DONE;
        end
      end
      S_TK_CMP: begin
        if (rem.due && scan_room) begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_TK_RD;
        end else begin
          out_until_nxt = rem.ticks_left;
          state_nxt     = S_TK_DONE;
        end
      end
      S_TK_DONE: begin
        em_nxt = '0;
        if (idx_r == '0) begin
          out_kind_nxt  = stq_pkg::KIND_TICK_NONE;
          out_tag_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT_ONE;
        end else begin
          state_nxt = S_EM_RD;
        end
      end
      // emit the due entries, then drop them from the head
      S_EM_RD: begin
        state_nxt = S_EM_LD;
      end
      S_EM_LD: begin
        out_kind_nxt  = stq_pkg::KIND_EXPIRED;
        out_tag_nxt   = rd_tag;
        out_last_nxt  = (em_inc == idx_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          em_nxt        = em_inc;
          if (out_last_r) begin
            head_nxt  = ring_addr(head_r, idx_r);
            cnt_nxt   = cnt_r - idx_r;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_EM_RD;
          end
        end
      end
      S_OUT_ONE: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    em_r        <= em_nxt;
    delay_r     <= delay_nxt;
    tag_r       <= tag_nxt;
    out_kind_r  <= out_kind_nxt;
    out_tag_r   <= out_tag_nxt;
    out_until_r <= out_until_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_until_r, out_tag_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // a result is only presented from an output wait state
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT_ONE || state_r == S_EM_OUT))
    else $error("result valid outside an output state");

  // the fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("pending count above depth");

  // the memory is written only by the insert walk
  a_wr_insert: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_INS_CMP || state_r == S_INS_PUT))
    else $error("memory write outside insert");

  // a tick advances the time base by exactly one
  a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == stq_pkg::OP_TICK) |=> (time_r == $past(time_r) + TW'(1)))
    else $error("tick did not advance time");

  // an emitted batch never exceeds the per-tick limit
  a_em_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EM_LD) |-> (32'(idx_r) <= stq_pkg::MAX_OUT && em_r < idx_r))
    else $error("expiry batch out of range");

endmodule
